### src/bmhq_pkg.sv
// shared constants, codes and types of the binary min-heap queue
`default_nettype none
package bmhq_pkg;

   localparam int CAPACITY_DEF  = 1024;
   localparam int KEY_WIDTH_DEF = 32;

   // fixed payload widths of the channels
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 11;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // compare unit modes
   localparam logic CMP_UP   = 1'b0;
   localparam logic CMP_DOWN = 1'b1;

   typedef struct packed {
      logic pick_b;   // right child is the smaller one
      logic hit;      // up: key <= parent, down: key < chosen child
   } cmp_result_type;

endpackage
`default_nettype wire

### src/bmhq_if.sv
// request and response channel interfaces of the binary min-heap queue
`default_nettype none
interface bmhq_req_if;
   import bmhq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [VALUE_W-1:0]   value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bmhq_rsp_if;
   import bmhq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   min_value;
   logic [STATUS_W-1:0]  status;
   logic                 now_empty;
   logic [OCC_W-1:0]     occupancy;

   modport source (output valid, output min_value, output status, output now_empty,
                   output occupancy, input ready);
   modport sink   (input valid, input min_value, input status, input now_empty,
                   input occupancy, output ready);
endinterface
`default_nettype wire

### src/bmhq_ram.sv
// heap key memory: one write port, two registered read ports
`default_nettype none
module bmhq_ram #(
   parameter int DEPTH  = bmhq_pkg::CAPACITY_DEF,
   parameter int DATA_W = bmhq_pkg::KEY_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output logic      [DATA_W-1:0] rdata_a,
   output logic      [DATA_W-1:0] rdata_b
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule
`default_nettype wire

### src/bmhq_cmp.sv
// shared key compare unit for sift-up and sift-down steps
`default_nettype none
module bmhq_cmp #(
   parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                 mode,
   input  wire logic [KEY_WIDTH-1:0] key,
   input  wire logic [KEY_WIDTH-1:0] a,
   input  wire logic [KEY_WIDTH-1:0] b,
   input  wire logic                 b_ok,
   output bmhq_pkg::cmp_result_type  res
);
   import bmhq_pkg::*;

   logic                 pick_b;
   logic [KEY_WIDTH-1:0] chosen;

   always_comb begin
      // left child wins a tie
      pick_b = (mode == CMP_DOWN) && b_ok && (b < a);
      chosen = pick_b ? b : a;
      res.pick_b = pick_b;
      unique case (mode)
         CMP_UP:   res.hit = (key <= a);
         CMP_DOWN: res.hit = (key < chosen);
         default:  res.hit = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

### src/binary_min_heap_queue.sv
// binary min-heap priority queue: sequencer, memory and compare unit
//
// Requests arrive on req_if (kind 0 inserts value, kind 1 extracts the minimum);
// each request gives exactly one response on rsp_if with the extracted key, a
// status (done, full on insert, empty on extract), the emptiness flag and the
// occupancy after the request. Both channels transfer on valid and ready high.
// One request is worked on at a time: req_if.ready is high only while idle.
// An insert climbs the heap one level per step (parent read, then compare and
// write through the single memory write port); an extract reads root and last
// entry, then descends one level per step (both children read, then compare and
// write). Each request is finished before the next is taken. The response sits in
// an output register, so a new request is taken while it waits; if the receiver
// stalls, the following response waits in its final state until the register
// frees. Reset (synchronous) empties the queue and drops any pending response;
// the key memory itself is not cleared and needs no clearing pass.
`default_nettype none
module binary_min_heap_queue #(
   parameter int CAPACITY  = bmhq_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bmhq_req_if.sink   req_if,
   bmhq_rsp_if.source rsp_if
);
   import bmhq_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_UP_CHK   = 3'd1;
   localparam logic [2:0] ST_UP_CMP   = 3'd2;
   localparam logic [2:0] ST_EXT_LOAD = 3'd3;
   localparam logic [2:0] ST_DN_CHK   = 3'd4;
   localparam logic [2:0] ST_DN_CMP   = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]           state_ff,  state_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic [CNT_W-1:0]     pos_ff,    pos_in;
   logic [KEY_WIDTH-1:0] key_ff,    key_in;
   logic [KEY_WIDTH-1:0] top_ff,    top_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_min_ff,    rsp_min_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff,  rsp_empty_in;
   logic [OCC_W-1:0]     rsp_occ_ff,    rsp_occ_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [KEY_WIDTH-1:0] ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr_a;
   logic [ADDR_W-1:0]    ram_raddr_b;
   logic [KEY_WIDTH-1:0] ram_rdata_a;
   logic [KEY_WIDTH-1:0] ram_rdata_b;

   logic                 cmp_mode;
   logic                 cmp_b_ok;
   cmp_result_type       cmp_res;

   logic [KEY_WIDTH+VALUE_W-1:0] value_wide;
   logic [KEY_WIDTH+VALUE_W-1:0] top_wide;
   logic [CNT_W+OCC_W-1:0]       count_wide;
   logic [KEY_WIDTH-1:0]         req_key;

   logic [CNT_W-1:0]     pos_m1;
   logic [CNT_W-1:0]     parent_pos;
   logic [CNT_W-1:0]     parent_m1;
   logic [CNT_W:0]       twice;
   logic [CNT_W:0]       twice_m1;
   logic [CNT_W:0]       twice_p1;
   logic [CNT_W:0]       count_ext;
   logic [CNT_W-1:0]     count_m1;
   logic [CNT_W:0]       child_pos;
   logic                 accept;
   logic                 out_free;
   logic                 full;

   bmhq_ram #(
      .DEPTH  (CAPACITY),
      .DATA_W (KEY_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   bmhq_cmp #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_cmp (
      .mode (cmp_mode),
      .key  (key_ff),
      .a    (ram_rdata_a),
      .b    (ram_rdata_b),
      .b_ok (cmp_b_ok),
      .res  (cmp_res)
   );

   // width adaption between channel fields and internal keys and counts
   assign value_wide = {{KEY_WIDTH{1'b0}}, req_if.value};
   assign req_key    = value_wide[KEY_WIDTH-1:0];
   assign top_wide   = {{VALUE_W{1'b0}}, top_ff};
   assign count_wide = {{OCC_W{1'b0}}, count_ff};

   assign pos_m1     = pos_ff - 1'b1;
   assign parent_pos = pos_ff >> 1;
   assign parent_m1  = parent_pos - 1'b1;
   assign twice      = {pos_ff, 1'b0};
   assign twice_m1   = twice - 1'b1;
   assign twice_p1   = twice + 1'b1;
   assign count_ext  = {1'b0, count_ff};
   assign count_m1   = count_ff - 1'b1;
   assign child_pos  = cmp_res.pick_b ? twice_p1 : twice;
   assign full       = (count_ext == (CNT_W+1)'(CAPACITY));

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign cmp_b_ok     = (twice_p1 <= count_ext);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      key_in      = key_ff;
      top_in      = top_ff;
      status_in   = status_ff;
      ram_we      = 1'b0;
      ram_waddr   = pos_m1[ADDR_W-1:0];
      ram_wdata   = key_ff;
      ram_raddr_a = '0;
      ram_raddr_b = '0;
      cmp_mode    = CMP_UP;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               top_in    = '0;
               key_in    = req_key;
               status_in = STAT_DONE;
               if (req_if.kind == KIND_INSERT) begin
                  if (full) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     count_in = count_ff + 1'b1;
                     pos_in   = count_ff + 1'b1;
                     state_in = ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     // root on port a, last entry on port b
                     ram_raddr_a = '0;
                     ram_raddr_b = count_m1[ADDR_W-1:0];
                     count_in    = count_m1;
                     state_in    = ST_EXT_LOAD;
                  end
               end
            end
         end
         ST_UP_CHK: begin
            if (pos_ff == CNT_W'(1)) begin
               ram_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               ram_raddr_a = parent_m1[ADDR_W-1:0];
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmp_mode = CMP_UP;
            ram_we   = 1'b1;
            if (cmp_res.hit) begin
               // parent moves down into the hole
               ram_wdata = ram_rdata_a;
               pos_in    = parent_pos;
               state_in  = ST_UP_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EXT_LOAD: begin
            top_in   = ram_rdata_a;
            key_in   = ram_rdata_b;
            pos_in   = CNT_W'(1);
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (twice > count_ext) begin
               ram_we   = (count_ff != '0);
               state_in = ST_DONE;
            end else begin
               ram_raddr_a = twice_m1[ADDR_W-1:0];
               ram_raddr_b = twice[ADDR_W-1:0];
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            cmp_mode = CMP_DOWN;
            ram_we   = 1'b1;
            if (cmp_res.hit) begin
               state_in = ST_DONE;
            end else begin
               // smaller child moves up into the hole
               ram_wdata = cmp_res.pick_b ? ram_rdata_b : ram_rdata_a;
               pos_in    = child_pos[CNT_W-1:0];
               state_in  = ST_DN_CHK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = top_wide[VALUE_W-1:0];
               rsp_status_in = status_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_occ_in    = count_wide[OCC_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.min_value = rsp_min_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.now_empty = rsp_empty_ff;
   assign rsp_if.occupancy = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= (CNT_W+1)'(CAPACITY))
      else $error("entry count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE || state_ff == ST_EXT_LOAD) |-> !ram_we)
      else $error("memory written outside a sift step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request taken without starting work");

   a_down_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_CMP) |-> (twice <= count_ext))
      else $error("sift-down compare without a left child");

endmodule
`default_nettype wire

### bench/binary_min_heap_queue_tb.sv
// testbench for the binary min-heap queue: directed table, random traffic, heap predictor
module binary_min_heap_queue_tb;
   import bmhq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_DEPTH = CAPACITY_DEF;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [VALUE_W-1:0]  min_value;
      logic [STATUS_W-1:0] status;
      logic                now_empty;
      logic [OCC_W-1:0]    occupancy;
   } reply_type;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic               typed;   // reply below is taken as is
      reply_type          reply;
   } request_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam request_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{KIND_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 1'b1, 11'd0}},
      '{KIND_INSERT,  32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd1}},
      '{KIND_INSERT,  32'h0000_0000, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd2}},
      '{KIND_EXTRACT, 32'h1234_5678, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd1}},
      '{KIND_EXTRACT, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, STAT_DONE, 1'b1, 11'd0}},
      '{KIND_EXTRACT, 32'hDEAD_BEEF, 1'b1, '{32'h0, STAT_EMPTY, 1'b1, 11'd0}},
      '{KIND_INSERT,  32'h0000_0005, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd1}},
      '{KIND_INSERT,  32'h0000_0005, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd2}},
      '{KIND_INSERT,  32'h0000_0005, 1'b1, '{32'h0, STAT_DONE,  1'b0, 11'd3}},
      '{KIND_INSERT,  32'h0000_0003, 1'b0, '0},
      '{KIND_INSERT,  32'h8000_0000, 1'b0, '0},
      '{KIND_INSERT,  32'h7FFF_FFFF, 1'b0, '0},
      '{KIND_INSERT,  32'h0000_0001, 1'b0, '0},
      '{KIND_INSERT,  32'hAAAA_AAAA, 1'b0, '0},
      '{KIND_INSERT,  32'h5555_5555, 1'b0, '0},
      '{KIND_EXTRACT, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_EXTRACT, 32'h0000_0000, 1'b0, '0},
      '{KIND_EXTRACT, 32'h5555_5555, 1'b0, '0},
      '{KIND_EXTRACT, 32'hAAAA_AAAA, 1'b0, '0},
      '{KIND_EXTRACT, 32'h0000_0001, 1'b0, '0},
      '{KIND_EXTRACT, 32'h7FFF_FFFF, 1'b0, '0},
      '{KIND_EXTRACT, 32'h8000_0000, 1'b0, '0},
      '{KIND_EXTRACT, 32'h0F0F_0F0F, 1'b0, '0},
      '{KIND_EXTRACT, 32'hF0F0_F0F0, 1'b0, '0},
      '{KIND_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 1'b1, 11'd0}}
   };

   logic clock;
   logic reset;

   bmhq_req_if req_if ();
   bmhq_rsp_if rsp_if ();

   binary_min_heap_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predictor state: keys at positions 1..heap_count
   logic [VALUE_W-1:0] heap_keys [1:HEAP_DEPTH];
   int                 heap_count = 0;

   reply_type pending_replies [$];
   int        fail_count = 0;
   int        items_sent = 0;
   int        send_gap_pct = 0;
   int        rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic reply_type predict_heap_reply(input logic kind,
                                                    input logic [VALUE_W-1:0] key);
      reply_type          r;
      int                 pos;
      int                 child;
      logic [VALUE_W-1:0] held;
      r = '0;
      r.status = STAT_DONE;
      if (kind == KIND_INSERT) begin
         if (heap_count >= HEAP_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            heap_count++;
            heap_keys[heap_count] = key;
            pos = heap_count;
            // sift up past equal parents too
            while (pos > 1 && heap_keys[pos] <= heap_keys[pos / 2]) begin
               held = heap_keys[pos];
               heap_keys[pos] = heap_keys[pos / 2];
               heap_keys[pos / 2] = held;
               pos = pos / 2;
            end
         end
      end else begin
         if (heap_count == 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.min_value = heap_keys[1];
            heap_keys[1] = heap_keys[heap_count];
            heap_count--;
            pos = 1;
            while (2 * pos <= heap_count) begin
               child = 2 * pos;
               if (child + 1 <= heap_count && heap_keys[child + 1] < heap_keys[child]) begin
                  child++;
               end
               if (heap_keys[pos] < heap_keys[child]) break;
               held = heap_keys[pos];
               heap_keys[pos] = heap_keys[child];
               heap_keys[child] = held;
               pos = child;
            end
         end
      end
      r.now_empty = (heap_count == 0);
      r.occupancy = heap_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] random_key();
      logic [VALUE_W-1:0] k;
      case ($urandom_range(0, 5))
         0:       k = '0;
         1:       k = '1;
         2, 3:    k = $urandom;
         4:       k = $urandom_range(0, 15);   // small keys make ties common
         default: k = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      endcase
      return k;
   endfunction

   task automatic send_request(input logic kind, input logic [VALUE_W-1:0] key,
                               input logic typed, input reply_type typed_reply);
      reply_type predicted;
      // idle pattern changes every 97 requests
      case ((items_sent / 97) % 4)
         0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_gap_pct = 47; rsp_stall_pct = 0;  end
         2: begin send_gap_pct = 0;  rsp_stall_pct = 47; end
         default: begin send_gap_pct = 13; rsp_stall_pct = 13; end
      endcase
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.value <= key;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_heap_reply(kind, key);
      pending_replies.push_back(typed ? typed_reply : predicted);
      items_sent++;
   endtask

   task automatic run_mix(input int count, input int insert_pct);
      repeat (count) begin
         send_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT,
                      random_key(), 1'b0, '0);
      end
   endtask

   // response side: random stall and check of every transfer
   always @(posedge clock) begin : rsp_check
      reply_type want;
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_replies.size() == 0) begin
            $error("response transfer with nothing pending: min_value %h status %0d",
                   rsp_if.min_value, rsp_if.status);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_if.min_value !== want.min_value) begin
               $error("min_value: expected %h, actual %h", want.min_value, rsp_if.min_value);
               fail_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               fail_count++;
            end
            if (rsp_if.now_empty !== want.now_empty) begin
               $error("now_empty: expected %0b, actual %0b", want.now_empty, rsp_if.now_empty);
               fail_count++;
            end
            if (rsp_if.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp_if.occupancy);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.kind  <= KIND_INSERT;
      req_if.value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         send_request(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].reply);
      end

      // shallow heap, frequent empty refusals
      run_mix(80, 50);
      // fill to capacity with a little extract noise
      while (heap_count < HEAP_DEPTH) begin
         send_request(($urandom_range(0, 99) < 95) ? KIND_INSERT : KIND_EXTRACT,
                      random_key(), 1'b0, '0);
      end
      run_mix(12, 100);
      run_mix(30, 50);
      // deep extracts among mostly inserts on a nearly full heap
      run_mix(120, 80);

      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
